// ===== src/bpfp_pkg.sv =====
// Shared constants for the BGRA pixel format packer.
`timescale 1ns / 1ps

package bpfp_pkg;

	// Configuration port geometry: two 32-bit registers at byte addresses 0 and 4.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register indexes, decoded from paddr[2].
	localparam logic REG_PIXEL_FORMAT  = 1'b0;
	localparam logic REG_BITMAP_LAYOUT = 1'b1;

	// Pixel format codes. The unused code is treated as color.
	localparam logic [1:0] FMT_BILEVEL = 2'd0;
	localparam logic [1:0] FMT_GRAY    = 2'd1;
	localparam logic [1:0] FMT_COLOR   = 2'd2;

	localparam logic [1:0] PIXEL_FORMAT_RESET  = FMT_COLOR;
	localparam logic       BITMAP_LAYOUT_RESET = 1'b0;

	// Luminance weights; the weighted sum never exceeds 255 * 1000.
	localparam int SUM_W = 18;
	localparam logic [9:0] W_RED   = 10'd299;
	localparam logic [9:0] W_GREEN = 10'd587;
	localparam logic [9:0] W_BLUE  = 10'd114;

	// Division by 1000 is a shift by 3 followed by a reciprocal multiply for 125.
	// The rounded-up reciprocal is exact for every sum up to 255000.
	localparam int PRE_SHIFT   = 3;
	localparam int QUOT_IN_W   = SUM_W - PRE_SHIFT;
	localparam int RECIP_W     = 16;
	localparam int PROD_W      = QUOT_IN_W + RECIP_W;
	localparam int RECIP_SHIFT = 22;
	localparam logic [RECIP_W-1:0] RECIP_125 = 16'd33555;

	localparam logic [7:0] BILEVEL_THRESHOLD = 8'd128;
	localparam logic [7:0] BILEVEL_MSB       = 8'h80;

endpackage

// ===== src/bpfp_pixel_if.sv =====
// Pixel input channel: one BGR pixel with its row-end flag per transaction.
`timescale 1ns / 1ps

interface bpfp_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic       row_end;

	modport source (output valid, output blue, output green, output red, output row_end,
		input ready);
	modport sink (input valid, input blue, input green, input red, input row_end,
		output ready);
endinterface

// ===== src/bpfp_byte_if.sv =====
// Byte output channel: one packed output byte with its markers per transaction.
`timescale 1ns / 1ps

interface bpfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       row_done;
	logic       last;

	modport source (output valid, output out_byte, output row_done, output last,
		input ready);
	modport sink (input valid, input out_byte, input row_done, input last,
		output ready);
endinterface

// ===== src/bgra_pixel_format_packer_top.sv =====
// Top level of the BGRA pixel format packer.
`timescale 1ns / 1ps

// Usage:
// Pixels enter on pix_in, one transaction per pixel, with row_end set on the
// last pixel of each row. Packed bytes leave on byte_out, one per transaction;
// last marks the final byte caused by a pixel and row_done the final byte of a
// row, padding included. A bilevel pixel that does not complete a byte yields
// no byte at all.
// The pixel passes an input register, a weighted-sum register and a luminance
// register, then enters the byte sequencer, which puts each byte into the output
// register. The sequencer sends one byte per cycle while byte_out accepts them;
// a pixel yields one byte in gray mode, at most one in bilevel mode and three in
// color mode, plus its pad bytes at a row end in bitmap layout (up to six in all).
// The three front stages keep accepting pixels while a byte waits in the
// output register. When byte_out stalls, the output register holds its
// transaction and the stages fill up before pix_in.ready falls.
// Reset clears all stages, the bit packer and the row phase, and sets the
// format to color with raster layout. The user must write registers over the
// APB port only while no pixel is in flight; the block does not enforce this.

module bgra_pixel_format_packer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	bpfp_pixel_if.sink                    pix_in,
	bpfp_byte_if.source                   byte_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpfp_pkg::ADDR_W-1:0]   paddr,
	input  logic [bpfp_pkg::DATA_W-1:0]   pwdata,
	output logic [bpfp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import bpfp_pkg::*;

	// Configuration registers
	logic [1:0] pixel_format_q;
	logic       bitmap_layout_q;
	logic       cfg_wr;

	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q  <= PIXEL_FORMAT_RESET;
			bitmap_layout_q <= BITMAP_LAYOUT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_PIXEL_FORMAT: begin
					pixel_format_q <= pwdata[1:0];
				end
				REG_BITMAP_LAYOUT: begin
					bitmap_layout_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_PIXEL_FORMAT: begin
				prdata[1:0] = pixel_format_q;
			end
			REG_BITMAP_LAYOUT: begin
				prdata[0] = bitmap_layout_q;
			end
			default: begin
			end
		endcase
	end

	// Front pipeline: input register, weighted sum, luminance
	logic             valid_s1, valid_s2, valid_s3;
	logic             ready_s1, ready_s2, ready_s3;
	logic [7:0]       blue_s1, green_s1, red_s1;
	logic             row_end_s1;
	logic [7:0]       blue_s2, green_s2, red_s2;
	logic             row_end_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [7:0]       blue_s3, green_s3, red_s3;
	logic             row_end_s3;
	logic [7:0]       lum_s3;
	logic [SUM_W-1:0] sum_next;
	logic [PROD_W-1:0] quot_prod;
	logic             load;

	assign ready_s3     = !valid_s3 || load;
	assign ready_s2     = !valid_s2 || ready_s3;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign pix_in.ready = ready_s1;

	assign sum_next = SUM_W'(red_s1) * SUM_W'(W_RED) + SUM_W'(green_s1) * SUM_W'(W_GREEN)
		+ SUM_W'(blue_s1) * SUM_W'(W_BLUE);
	assign quot_prod = PROD_W'(sum_s2[SUM_W-1:PRE_SHIFT]) * PROD_W'(RECIP_125);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pix_in.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.valid && ready_s1) begin
			blue_s1    <= pix_in.blue;
			green_s1   <= pix_in.green;
			red_s1     <= pix_in.red;
			row_end_s1 <= pix_in.row_end;
		end
		if (valid_s1 && ready_s2) begin
			blue_s2    <= blue_s1;
			green_s2   <= green_s1;
			red_s2     <= red_s1;
			row_end_s2 <= row_end_s1;
			sum_s2     <= sum_next;
		end
		if (valid_s2 && ready_s3) begin
			blue_s3    <= blue_s2;
			green_s3   <= green_s2;
			red_s3     <= red_s2;
			row_end_s3 <= row_end_s2;
			lum_s3     <= quot_prod[RECIP_SHIFT +: 8];
		end
	end

	// Byte sequencer: the pixel's whole byte list is settled when it loads,
	// then the bytes go out one per cycle while the output register can take them.
	logic [7:0] bit_acc_q;
	logic [2:0] bit_pos_q;
	logic [1:0] phase_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic [2:0] cnt_q;
	logic [1:0] nd_q;
	logic [7:0] data_q [3];
	logic       row_end_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_row_done_q;
	logic       out_last_q;

	logic       emit_fire;
	logic       emit_last;
	logic [7:0] emit_byte;

	logic [7:0] acc_or;
	logic [2:0] pos_inc;
	logic [7:0] d0, d1, d2;
	logic [1:0] nd;
	logic [1:0] phase_after;
	logic [1:0] pads;
	logic [2:0] n_total;
	logic [7:0] acc_nx;
	logic [2:0] pos_nx;
	logic [1:0] phase_nx;

	assign emit_fire = busy_q && (!out_valid_q || byte_out.ready);
	assign emit_last = (idx_q == cnt_q - 3'd1);
	assign load      = valid_s3 && (!busy_q || (emit_fire && emit_last));
	assign emit_byte = (idx_q < {1'b0, nd_q}) ? data_q[idx_q[1:0]] : 8'h00;

	always_comb begin
		acc_or  = bit_acc_q | ((lum_s3 >= BILEVEL_THRESHOLD) ? (BILEVEL_MSB >> bit_pos_q) : 8'h00);
		pos_inc = bit_pos_q + 3'd1;
		d0      = 8'h00;
		d1      = 8'h00;
		d2      = 8'h00;
		nd      = 2'd0;
		acc_nx  = bit_acc_q;
		pos_nx  = bit_pos_q;
		case (pixel_format_q)
			FMT_BILEVEL: begin
				if (pos_inc == 3'd0 || row_end_s3) begin
					nd     = 2'd1;
					d0     = acc_or;
					acc_nx = 8'h00;
					pos_nx = 3'd0;
				end else begin
					acc_nx = acc_or;
					pos_nx = pos_inc;
				end
			end
			FMT_GRAY: begin
				nd = 2'd1;
				d0 = lum_s3;
			end
			default: begin
				nd = 2'd3;
				if (bitmap_layout_q) begin
					d0 = blue_s3;
					d1 = green_s3;
					d2 = red_s3;
				end else begin
					d0 = red_s3;
					d1 = green_s3;
					d2 = blue_s3;
				end
			end
		endcase
		phase_after = phase_q + nd;
		// In bitmap layout, pad bytes bring the row length up to a multiple of four.
		pads     = (row_end_s3 && bitmap_layout_q) ? 2'd0 - phase_after : 2'd0;
		n_total  = {1'b0, nd} + {1'b0, pads};
		phase_nx = row_end_s3 ? 2'd0 : phase_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_acc_q      <= '0;
			bit_pos_q      <= '0;
			phase_q        <= '0;
			busy_q         <= 1'b0;
			idx_q          <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (load) begin
				bit_acc_q <= acc_nx;
				bit_pos_q <= pos_nx;
				phase_q   <= phase_nx;
				busy_q    <= (n_total != 3'd0);
				idx_q     <= 3'd0;
				cnt_q     <= n_total;
			end else if (emit_fire) begin
				idx_q <= idx_q + 3'd1;
				if (emit_last) begin
					busy_q <= 1'b0;
				end
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (byte_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nd_q      <= nd;
			data_q[0] <= d0;
			data_q[1] <= d1;
			data_q[2] <= d2;
			row_end_q <= row_end_s3;
		end
		if (emit_fire) begin
			out_byte_q     <= emit_byte;
			out_row_done_q <= emit_last && row_end_q;
			out_last_q     <= emit_last;
		end
	end

	assign byte_out.valid    = out_valid_q;
	assign byte_out.out_byte = out_byte_q;
	assign byte_out.row_done = out_row_done_q;
	assign byte_out.last     = out_last_q;

`ifndef ASSERT_OFF
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < cnt_q))
		else $error("byte index ran past the byte count of the pixel");

	a_row_phase_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(load && row_end_s3) |=> (phase_q == 2'd0))
		else $error("row phase not cleared after a row end");

	a_bitmap_row_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(load && row_end_s3 && bitmap_layout_q) |-> (2'(phase_after + pads) == 2'd0))
		else $error("bitmap row does not end on a four-byte boundary");

	a_row_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_row_done_q) |-> out_last_q)
		else $error("row_done set on a byte that is not the last of its pixel");

	a_row_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(load && row_end_s3) |=> busy_q)
		else $error("a row-end pixel produced no bytes");
`endif

endmodule
